[design/lpd_pkg.sv]
// Package for the length-prefixed deframer: beat payload types and the parse phase.
// No dependencies; lpd_if and length_prefixed_deframer_core use it.
`timescale 1ns / 1ps

package lpd_pkg;

    typedef enum logic [1:0] {
        PH_HDR_HI = 2'd0,
        PH_HDR_LO = 2'd1,
        PH_LEN    = 2'd2,
        PH_PAY    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_beat_t;

    typedef struct packed {
        logic [13:0] msg_type;
        logic [7:0]  payload_byte;
        logic        has_payload;
        logic        last_byte;
    } msg_beat_t;

endpackage

[design/lpd_if.sv]
// Valid/ready channel interfaces for the deframer's byte input and message output.
// Depends on lpd_pkg for the beat types.
`timescale 1ns / 1ps

interface lpd_rx_if;
    logic              valid;
    logic              ready;
    lpd_pkg::rx_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpd_msg_if;
    logic               valid;
    logic               ready;
    lpd_pkg::msg_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/length_prefixed_deframer_core.sv]
// Length-prefixed deframer: takes one stream byte per beat and takes it apart into
// typed message bytes. One byte per cycle; the only wait is a held output beat that
// the sink has not taken. A byte is processed in the cycle it is accepted and its
// result, if any, appears in the output register on the next cycle. Header and
// length bytes produce no output beat, except that a zero-length message produces one
// empty beat from its last header or length byte. Depends on lpd_pkg and lpd_if.
`timescale 1ns / 1ps

module length_prefixed_deframer_core #(
    parameter int MAX_LENGTH_BYTES = 3
) (
    input logic       clk,
    input logic       rst_n,
    lpd_rx_if.sink    rx,
    lpd_msg_if.source msg
);

    localparam int LEN_W = 8 * MAX_LENGTH_BYTES;

    lpd_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]         header_high_reg, header_high_next;
    logic [13:0]        type_reg, type_next;
    logic [1:0]         len_left_reg, len_left_next;
    logic [LEN_W-1:0]   pay_left_reg, pay_left_next;
    logic               out_valid_reg;
    lpd_pkg::msg_beat_t out_data_reg;

    logic               rx_fire;
    logic               emit;
    lpd_pkg::msg_beat_t emit_data;
    logic [LEN_W+7:0]   len_shift;
    logic [LEN_W-1:0]   pay_dec;
    logic [1:0]         len_dec;
    logic [7:0]         b;

    assign b        = rx.data.rx_byte;
    assign rx.ready = !out_valid_reg || msg.ready;
    assign rx_fire  = rx.valid && rx.ready;

    assign len_shift = {pay_left_reg, b};
    assign pay_dec   = pay_left_reg - LEN_W'(1);
    assign len_dec   = len_left_reg - 2'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            lpd_pkg::PH_HDR_HI:
                phase_next = lpd_pkg::PH_HDR_LO;
            lpd_pkg::PH_HDR_LO:
                phase_next = (b[1:0] == 2'd0) ? lpd_pkg::PH_HDR_HI : lpd_pkg::PH_LEN;
            lpd_pkg::PH_LEN:
            begin
                if (len_dec == 2'd0)
                begin
                    phase_next = (len_shift[LEN_W-1:0] == '0) ? lpd_pkg::PH_HDR_HI
                                                              : lpd_pkg::PH_PAY;
                end
            end
            lpd_pkg::PH_PAY:
                phase_next = (pay_dec == '0) ? lpd_pkg::PH_HDR_HI : lpd_pkg::PH_PAY;
            default:
                phase_next = lpd_pkg::PH_HDR_HI;
        endcase
    end

    // datapath and result
    always_comb
    begin
        header_high_next       = header_high_reg;
        type_next              = type_reg;
        len_left_next          = len_left_reg;
        pay_left_next          = pay_left_reg;
        emit                   = 1'b0;
        emit_data.msg_type     = type_reg;
        emit_data.payload_byte = 8'd0;
        emit_data.has_payload  = 1'b0;
        emit_data.last_byte    = 1'b1;
        unique case (phase_reg)
            lpd_pkg::PH_HDR_HI:
                header_high_next = b;
            lpd_pkg::PH_HDR_LO:
            begin
                type_next          = {header_high_reg, b[7:2]};
                len_left_next      = b[1:0];
                pay_left_next      = '0;
                emit               = (b[1:0] == 2'd0);
                emit_data.msg_type = {header_high_reg, b[7:2]};
            end
            lpd_pkg::PH_LEN:
            begin
                pay_left_next = len_shift[LEN_W-1:0];
                len_left_next = len_dec;
                emit          = (len_dec == 2'd0) && (len_shift[LEN_W-1:0] == '0);
            end
            lpd_pkg::PH_PAY:
            begin
                pay_left_next          = pay_dec;
                emit                   = 1'b1;
                emit_data.payload_byte = b;
                emit_data.has_payload  = 1'b1;
                emit_data.last_byte    = (pay_dec == '0);
            end
            default:
                emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lpd_pkg::PH_HDR_HI;
            header_high_reg <= '0;
            type_reg        <= '0;
            len_left_reg    <= '0;
            pay_left_reg    <= '0;
        end
        else if (rx_fire)
        begin
            phase_reg       <= phase_next;
            header_high_reg <= header_high_next;
            type_reg        <= type_next;
            len_left_reg    <= len_left_next;
            pay_left_reg    <= pay_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rx_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (msg.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload register: load only when a new beat goes out
    always_ff @(posedge clk)
    begin
        if (rx_fire && emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    assign msg.valid = out_valid_reg;
    assign msg.data  = out_data_reg;

endmodule

[design/lpd_checker.sv]
// Port-level checks for the length-prefixed deframer, bound to its top level.
// Depends on length_prefixed_deframer_core and lpd_if.
`timescale 1ns / 1ps

module lpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic [13:0] msg_type,
    input logic [7:0]  payload_byte,
    input logic        has_payload,
    input logic        last_byte
);

    // a held beat keeps its contents
    a_msg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid && $stable(msg_type)
            && $stable(payload_byte) && $stable(has_payload) && $stable(last_byte))
        else $error("output beat changed while stalled");

    // an empty output register never blocks input
    a_rx_free: assert property (@(posedge clk) disable iff (!rst_n)
        !msg_valid |-> rx_ready)
        else $error("input stalled with empty output");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !has_payload |-> last_byte && payload_byte == 8'd0)
        else $error("empty-message beat malformed");

    // a new output beat appears only in the cycle after an accepted byte
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_valid) |-> $past(rx_valid && rx_ready))
        else $error("output beat without input byte");

endmodule

bind length_prefixed_deframer_core lpd_checker u_lpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .msg_type     (msg.data.msg_type),
    .payload_byte (msg.data.payload_byte),
    .has_payload  (msg.data.has_payload),
    .last_byte    (msg.data.last_byte)
);
